### hw/rtl/framed_packet_parser_xor_ack_unit_defines.svh
// Assertion macros used by the reply queue RTL.
`ifndef FRAMED_PACKET_PARSER_XOR_ACK_UNIT_DEFINES_SVH
`define FRAMED_PACKET_PARSER_XOR_ACK_UNIT_DEFINES_SVH

// Checked at every clock edge outside reset.
`define FPPX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FPPX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/fppx_pkg.sv
`default_nettype none

package fppx_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'hA5;
    localparam logic [7:0]  REPLY_SYNC     = 8'h5A;
    localparam logic [7:0]  STATUS_OK      = 8'h00;
    localparam logic [7:0]  STATUS_LENGTH  = 8'h02;
    localparam logic [7:0]  STATUS_CHECK   = 8'h03;

    localparam logic [7:0]  MAX_LENGTH_RST = 8'd32;
    localparam logic [15:0] TIMEOUT_RST    = 16'd30;

    localparam int          ADDR_W         = 3;

    typedef enum logic {
        REG_MAX_LENGTH    = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        BYTE_SYNC   = 2'd0,
        BYTE_SEQ_LO = 2'd1,
        BYTE_SEQ_HI = 2'd2,
        BYTE_STATUS = 2'd3
    } reply_pos_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  status;
    } reply_t;

    typedef struct packed {
        logic   push;
        reply_t reply;
    } reply_req_t;

endpackage

`default_nettype wire

### hw/rtl/fppx_parser.sv
`default_nettype none

module fppx_parser
    import fppx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        cmd,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  max_length,
    input  wire logic [15:0] timeout_ticks,
    output reply_req_t       req
);

    typedef enum logic [2:0] {
        PH_SYNC    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN     = 3'd2,
        PH_SEQLO   = 3'd3,
        PH_SEQHI   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  length_reg,  length_next;
    logic [7:0]  count_reg,   count_next;
    logic [15:0] seq_reg,     seq_next;
    logic [7:0]  accum_reg,   accum_next;
    logic [15:0] idle_reg,    idle_next;
    logic [7:0]  count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        seq_next    = seq_reg;
        accum_next  = accum_reg;
        idle_next   = idle_reg;
        req         = '0;
        req.reply.seq = seq_reg;

        if (accept)
        begin
            if (cmd)
            begin
                if (idle_reg != 16'hFFFF)
                begin
                    idle_next = idle_reg + 16'd1;
                end
                if (phase_reg != PH_SYNC && idle_next > timeout_ticks)
                begin
                    phase_next = PH_SYNC;
                    count_next = '0;
                    accum_next = '0;
                end
            end
            else
            begin
                idle_next = '0;
                case (phase_reg)
                    PH_CMD:
                    begin
                        accum_next = rx_byte;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        length_next = rx_byte;
                        if (rx_byte > max_length)
                        begin
                            req.push         = 1'b1;
                            req.reply.status = STATUS_LENGTH;
                            phase_next       = PH_SYNC;
                            count_next       = '0;
                            accum_next       = '0;
                        end
                        else
                        begin
                            accum_next = accum_reg ^ rx_byte;
                            phase_next = PH_SEQLO;
                        end
                    end
                    PH_SEQLO:
                    begin
                        seq_next   = {8'h00, rx_byte};
                        accum_next = accum_reg ^ rx_byte;
                        phase_next = PH_SEQHI;
                    end
                    PH_SEQHI:
                    begin
                        seq_next   = {rx_byte, seq_reg[7:0]};
                        accum_next = accum_reg ^ rx_byte;
                        count_next = '0;
                        phase_next = (length_reg == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        count_next = count_inc;
                        accum_next = accum_reg ^ rx_byte;
                        if (count_inc == length_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        req.push         = 1'b1;
                        req.reply.status = (rx_byte == accum_reg) ? STATUS_OK : STATUS_CHECK;
                        phase_next       = PH_SYNC;
                        count_next       = '0;
                        accum_next       = '0;
                    end
                    default:
                    begin
                        phase_next = (rx_byte == SYNC_BYTE) ? PH_CMD : PH_SYNC;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC;
            length_reg <= '0;
            count_reg  <= '0;
            seq_reg    <= '0;
            accum_reg  <= '0;
            idle_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            seq_reg    <= seq_next;
            accum_reg  <= accum_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fppx_reply_queue.sv
`default_nettype none

`include "framed_packet_parser_xor_ack_unit_defines.svh"

module fppx_reply_queue
    import fppx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire reply_req_t req,
    output logic            full,
    output logic            valid,
    input  wire logic       stall,
    output logic [7:0]      reply_byte,
    output logic            last_byte
);

    reply_t     head_reg,  head_next;
    reply_t     tail_reg,  tail_next;
    logic [1:0] cnt_reg,   cnt_next;
    reply_pos_t pos_reg,   pos_next;
    logic [1:0] cnt_after_pop;
    logic       out_accept;
    logic       pop;

    assign full       = (cnt_reg == 2'd2);
    assign valid      = (cnt_reg != 2'd0);
    assign out_accept = valid && !stall;
    assign pop        = out_accept && (pos_reg == BYTE_STATUS);
    assign last_byte  = (pos_reg == BYTE_STATUS);

    always_comb
    begin
        case (pos_reg)
            BYTE_SYNC:   reply_byte = REPLY_SYNC;
            BYTE_SEQ_LO: reply_byte = head_reg.seq[7:0];
            BYTE_SEQ_HI: reply_byte = head_reg.seq[15:8];
            BYTE_STATUS: reply_byte = head_reg.status;
            default:     reply_byte = REPLY_SYNC;
        endcase
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        pos_next      = pos_reg;
        cnt_after_pop = cnt_reg;

        if (out_accept)
        begin
            pos_next = reply_pos_t'(pos_reg + 2'd1);
        end
        if (pop)
        begin
            head_next     = tail_reg;
            cnt_after_pop = cnt_reg - 2'd1;
        end

        cnt_next = cnt_after_pop;
        if (req.push)
        begin
            if (cnt_after_pop == 2'd0)
            begin
                head_next = req.reply;
            end
            else
            begin
                tail_next = req.reply;
            end
            cnt_next = cnt_after_pop + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= BYTE_SYNC;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    `FPPX_ASSERT_ALWAYS(a_cnt_bound, (cnt_reg != 2'd3), "reply queue count out of range")
    `FPPX_ASSERT(a_no_push_full, (req.push |-> !full), "reply pushed into full queue")
    `FPPX_ASSERT(a_pos_needs_entry, ((pos_reg != BYTE_SYNC) |-> valid), "reply position without entry")
    `FPPX_ASSERT(a_pop_drains, ((pop && !req.push) |=> (cnt_reg == $past(cnt_reg) - 2'd1)), "pop lost")

endmodule

`default_nettype wire

### hw/rtl/framed_packet_parser_xor_ack_unit.sv
// Channel   | Handshake                | Payload
// ----------+--------------------------+---------------------
// rx        | rx_valid / rx_stall      | cmd, rx_byte
// reply     | reply_valid / reply_stall| reply_byte, last_byte
// config    | APB psel/penable/pwrite  | paddr, pwdata, prdata
//
// One rx transaction per cycle while rx_stall is low; parser state updates at the accepting edge.
// A reply enters a two-entry queue at that edge and drains as four reply
// transactions, one per cycle while reply_stall is low.
// rx_stall rises only while the reply queue holds two replies.
// rst_n is asynchronous and clears the parser to sync search, the queue, and
// the registers to max_length 32 and timeout_ticks 30.
`default_nettype none

module framed_packet_parser_xor_ack_unit
    import fppx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,

    input  wire logic              rx_valid,
    output logic                   rx_stall,
    input  wire logic              cmd,
    input  wire logic [7:0]        rx_byte,

    output logic                   reply_valid,
    input  wire logic              reply_stall,
    output logic      [7:0]        reply_byte,
    output logic                   last_byte
);

    logic [7:0]  max_length_reg;
    logic [15:0] timeout_reg;
    reg_index_t  reg_sel;
    logic        cfg_write;
    logic        rx_accept;
    logic        queue_full;
    reply_req_t  req;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[ADDR_W-1]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign rx_stall  = queue_full;
    assign rx_accept = rx_valid && !rx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_MAX_LENGTH:    max_length_reg <= pwdata[7:0];
                REG_TIMEOUT_TICKS: timeout_reg    <= pwdata[15:0];
                default:           max_length_reg <= max_length_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MAX_LENGTH:    prdata = {24'h000000, max_length_reg};
            REG_TIMEOUT_TICKS: prdata = {16'h0000, timeout_reg};
            default:           prdata = '0;
        endcase
    end

    fppx_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (rx_accept),
        .cmd           (cmd),
        .rx_byte       (rx_byte),
        .max_length    (max_length_reg),
        .timeout_ticks (timeout_reg),
        .req           (req)
    );

    fppx_reply_queue u_reply_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .full       (queue_full),
        .valid      (reply_valid),
        .stall      (reply_stall),
        .reply_byte (reply_byte),
        .last_byte  (last_byte)
    );

endmodule

`default_nettype wire
